[rtl/piecewise_linear_interpolator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear interpolator
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_DEFINES_SVH

// consequent checked in the same cycle
`define PLI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the following cycle
`define PLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/pli_pkg.sv]
// ----------------------------------------------------------------------------
// pli_pkg
// Types and constants shared by the interpolator controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pli_pkg;

	localparam int DATA_W = 16;
	localparam int CNT_W  = 5;
	localparam int IDX_W  = 4;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;

	// breakpoint store read address select
	typedef enum logic [1:0] {
		RD_FIRST,
		RD_SECOND,
		RD_LAST,
		RD_NEXT
	} rd_sel_t;

	// source of the staged result
	typedef enum logic [2:0] {
		RES_FEW,
		RES_NONE,
		RES_NODE_Y,
		RES_LEFT_Y,
		RES_QUOT
	} res_sel_t;

	typedef struct packed {
		logic     wr_en;
		logic     start;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     cap_prev;
		logic     idx_init;
		logic     idx_inc;
		logic     seg_latch;
		logic     div_init;
		logic     div_step;
		logic     res_set;
		res_sel_t res_sel;
		logic     load_out;
	} pli_cmd_t;

	typedef struct packed {
		logic few;
		logic le_first;
		logic ge_last;
		logic seg_hit;
		logic seg_flat;
		logic at_last;
		logic div_last;
	} pli_sts_t;

endpackage

[rtl/pli_dp.sv]
// ----------------------------------------------------------------------------
// pli_dp
// Breakpoint store, segment scan registers, 16x16 multiplier, restoring
// divider and result/output registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_dp #(
	parameter int MAX_NODES = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pli_pkg::pli_cmd_t                   cmd,
	output pli_pkg::pli_sts_t                   sts,
	input  logic                                cfg_valid,
	input  logic        [pli_pkg::CNT_W-1:0]    cfg_data,
	input  logic        [pli_pkg::IDX_W-1:0]    node_index,
	input  logic signed [pli_pkg::DATA_W-1:0]   node_x,
	input  logic signed [pli_pkg::DATA_W-1:0]   node_y,
	input  logic signed [pli_pkg::DATA_W-1:0]   query_x,
	output logic signed [pli_pkg::DATA_W-1:0]   value_y,
	output logic                                table_too_small
);
	import pli_pkg::*;

	localparam int AW = $clog2(MAX_NODES);
	localparam int CW = $clog2(MAX_NODES + 1);

	logic [2*DATA_W-1:0] mem [MAX_NODES];

	logic [CNT_W-1:0]         node_count_q;
	logic [CW-1:0]            n_cur;
	logic [CW-1:0]            n_q;
	logic [AW-1:0]            idx_q;
	logic [AW-1:0]            rd_addr;
	logic [AW-1:0]            wr_addr;
	logic [2*DATA_W-1:0]      rd_q;
	logic signed [DATA_W-1:0] qx_q;
	logic signed [DATA_W-1:0] cur_x;
	logic signed [DATA_W-1:0] cur_y;
	logic signed [DATA_W-1:0] prev_x_q;
	logic signed [DATA_W-1:0] prev_y_q;

	logic signed [DATA_W:0]   dy;
	logic signed [DATA_W:0]   dy_neg;
	logic signed [DATA_W:0]   dx;
	logic signed [DATA_W:0]   dw;
	logic                     neg_q;
	logic [DATA_W-1:0]        dy_abs_q;
	logic [DATA_W-1:0]        dx_q;
	logic [DATA_W-1:0]        den_q;
	logic signed [DATA_W-1:0] y0_q;

	logic [2*DATA_W-1:0]      dvd_q;
	logic [DATA_W-1:0]        rem_q;
	logic [4:0]               div_cnt_q;
	logic [DATA_W:0]          trial;
	logic                     trial_ge;

	logic [DATA_W:0]          q_ext;
	logic [DATA_W:0]          y_sum;
	logic signed [DATA_W-1:0] res_y_q;
	logic                     res_flag_q;
	logic signed [DATA_W-1:0] res_y;
	logic                     res_flag;

	// node count register, clamped to the store depth when used
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= '0;
		end else if (cfg_valid) begin
			node_count_q <= cfg_data;
		end
	end

	always_comb begin
		if (32'(node_count_q) > MAX_NODES) begin
			n_cur = CW'(MAX_NODES);
		end else begin
			n_cur = CW'(node_count_q);
		end
	end

	assign wr_addr = AW'(node_index);

	always_comb begin
		unique case (cmd.rd_sel)
			RD_FIRST:  rd_addr = '0;
			RD_SECOND: rd_addr = AW'(1);
			RD_LAST:   rd_addr = AW'(n_q - CW'(1));
			RD_NEXT:   rd_addr = idx_q + AW'(1);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && (32'(node_index) < MAX_NODES)) begin
			mem[wr_addr] <= {node_x, node_y};
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign cur_x = $signed(rd_q[2*DATA_W-1:DATA_W]);
	assign cur_y = $signed(rd_q[DATA_W-1:0]);

	assign dy     = {cur_y[DATA_W-1], cur_y} - {prev_y_q[DATA_W-1], prev_y_q};
	assign dy_neg = -dy;
	assign dx     = {qx_q[DATA_W-1], qx_q} - {prev_x_q[DATA_W-1], prev_x_q};
	assign dw     = {cur_x[DATA_W-1], cur_x} - {prev_x_q[DATA_W-1], prev_x_q};

	assign trial    = {rem_q, dvd_q[2*DATA_W-1]};
	assign trial_ge = trial >= {1'b0, den_q};

	// quotient magnitude never exceeds |y1 - y0|, so 16 bits hold it
	assign q_ext = neg_q ? -{1'b0, dvd_q[DATA_W-1:0]} : {1'b0, dvd_q[DATA_W-1:0]};
	assign y_sum = {y0_q[DATA_W-1], y0_q} + q_ext;

	always_comb begin
		res_y    = '0;
		res_flag = 1'b0;
		unique case (cmd.res_sel)
			RES_FEW:    res_flag = 1'b1;
			RES_NONE:   res_y = '0;
			RES_NODE_Y: res_y = cur_y;
			RES_LEFT_Y: res_y = prev_y_q;
			RES_QUOT:   res_y = $signed(y_sum[DATA_W-1:0]);
			default:    res_y = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qx_q <= query_x;
			n_q  <= n_cur;
		end
		if (cmd.cap_prev) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
		if (cmd.idx_init) begin
			idx_q <= AW'(1);
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.seg_latch) begin
			neg_q    <= dy[DATA_W];
			dy_abs_q <= dy[DATA_W] ? dy_neg[DATA_W-1:0] : dy[DATA_W-1:0];
			dx_q     <= dx[DATA_W-1:0];
			den_q    <= dw[DATA_W-1:0];
			y0_q     <= prev_y_q;
		end
		if (cmd.div_init) begin
			dvd_q     <= dy_abs_q * dx_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= trial_ge ? DATA_W'(trial - {1'b0, den_q}) : trial[DATA_W-1:0];
			dvd_q     <= {dvd_q[2*DATA_W-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + 5'd1;
		end
		if (cmd.res_set) begin
			res_y_q    <= res_y;
			res_flag_q <= res_flag;
		end
		if (cmd.load_out) begin
			value_y         <= res_y_q;
			table_too_small <= res_flag_q;
		end
	end

	assign sts.few      = n_cur < CW'(2);
	assign sts.le_first = qx_q <= cur_x;
	assign sts.ge_last  = qx_q >= cur_x;
	assign sts.seg_hit  = (qx_q >= prev_x_q) && (qx_q <= cur_x);
	assign sts.seg_flat = cur_x == prev_x_q;
	assign sts.at_last  = CW'(idx_q) == (n_q - CW'(1));
	assign sts.div_last = div_cnt_q == 5'd31;

endmodule

[rtl/pli_ctrl.sv]
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer for load and evaluate items: saturation checks, segment scan,
// multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_defines.svh"

module pli_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              opcode,
	output logic              out_valid,
	input  logic              out_ready,
	input  pli_pkg::pli_sts_t sts,
	output pli_pkg::pli_cmd_t cmd
);
	import pli_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_SCAN,
		S_MUL,
		S_DIV,
		S_RES,
		S_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (opcode == OP_LOAD) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start = 1'b1;
						if (sts.few) begin
							cmd.res_set = 1'b1;
							cmd.res_sel = RES_FEW;
						end else begin
							cmd.rd_en  = 1'b1;
							cmd.rd_sel = RD_FIRST;
						end
					end
				end
			end
			S_FIRST: begin
				if (sts.le_first) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_NODE_Y;
				end else begin
					cmd.cap_prev = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = RD_LAST;
				end
			end
			S_LAST: begin
				if (sts.ge_last) begin
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_NODE_Y;
				end else begin
					cmd.idx_init = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = RD_SECOND;
				end
			end
			S_SCAN: begin
				if (sts.seg_hit) begin
					if (sts.seg_flat) begin
						cmd.res_set = 1'b1;
						cmd.res_sel = RES_LEFT_Y;
					end else begin
						cmd.seg_latch = 1'b1;
					end
				end else if (sts.at_last) begin
					// only a non-ascending table gets here
					cmd.res_set = 1'b1;
					cmd.res_sel = RES_NONE;
				end else begin
					cmd.cap_prev = 1'b1;
					cmd.idx_inc  = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = RD_NEXT;
				end
			end
			S_MUL:  cmd.div_init = 1'b1;
			S_DIV:  cmd.div_step = 1'b1;
			S_RES: begin
				cmd.res_set = 1'b1;
				cmd.res_sel = RES_QUOT;
			end
			S_DONE: cmd.load_out = out_free;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && opcode == OP_EVAL) begin
						state_q <= sts.few ? S_DONE : S_FIRST;
					end
				end
				S_FIRST: state_q <= sts.le_first ? S_DONE : S_LAST;
				S_LAST:  state_q <= sts.ge_last ? S_DONE : S_SCAN;
				S_SCAN: begin
					if (sts.seg_hit) begin
						state_q <= sts.seg_flat ? S_DONE : S_MUL;
					end else if (sts.at_last) begin
						state_q <= S_DONE;
					end
				end
				S_MUL: state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_last) begin
						state_q <= S_RES;
					end
				end
				S_RES: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	`PLI_ASSERT_NEXT(a_eval_holds_input, accept && opcode == OP_EVAL, !in_ready, "evaluate item did not block input")
	`PLI_ASSERT_NEXT(a_load_single_cycle, accept && opcode == OP_LOAD, in_ready, "load item left the idle state")
	`PLI_ASSERT_SAME(a_no_result_overwrite, cmd.load_out, !out_valid_q || out_ready, "pending result overwritten")
	`PLI_ASSERT_SAME(a_result_from_done, $rose(out_valid_q), $past(state_q) == S_DONE, "result raised outside done state")

endmodule

[rtl/piecewise_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with linear interpolation between nodes, saturation
// outside the table and a flag for tables with fewer than two nodes.
// ----------------------------------------------------------------------------
//  channel  signals                                        direction
//  in       in_valid/in_ready, opcode, node_index,         input
//           node_x, node_y, query_x
//  out      out_valid/out_ready, value_y, table_too_small  output
//  cfg      cfg_valid/cfg_ready, cfg_data (node_count)     input
//
//  A load item writes one node into the store and stays idle. Evaluate: a table with fewer
//  than two nodes is flagged without a scan, a query at or outside the first or last node
//  saturates to that node's y, and the scan stops on a zero-width segment or at the last node
//  with no hit; a hit runs the one node per cycle scan plus a 32-step restoring divider.
//  Reset clears node_count and the control state, not the breakpoint store. A stalled
//  output holds the done state; the next item is taken once the result is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_interpolator #(
	parameter int MAX_NODES = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               opcode,
	input  logic        [pli_pkg::IDX_W-1:0]   node_index,
	input  logic signed [pli_pkg::DATA_W-1:0]  node_x,
	input  logic signed [pli_pkg::DATA_W-1:0]  node_y,
	input  logic signed [pli_pkg::DATA_W-1:0]  query_x,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [pli_pkg::DATA_W-1:0]  value_y,
	output logic                               table_too_small,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic        [pli_pkg::CNT_W-1:0]   cfg_data
);
	import pli_pkg::*;

	pli_cmd_t cmd;
	pli_sts_t sts;

	// configuration writes are always taken
	assign cfg_ready = 1'b1;

	pli_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pli_dp #(
		.MAX_NODES (MAX_NODES)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.node_index      (node_index),
		.node_x          (node_x),
		.node_y          (node_y),
		.query_x         (query_x),
		.value_y         (value_y),
		.table_too_small (table_too_small)
	);

endmodule
